FILE: hdl/ifp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifp_pkg - shared types and constants for the i-BUS frame parser
// Header bytes, checksum base, request codes and the frame-end event struct.
// ----------------------------------------------------------------------------
package ifp_pkg;

	// byte position counter width (frames up to 64 bytes)
	localparam int POS_W = 6;

	// default geometry
	localparam int FRAME_BYTES_DEF  = 32;
	localparam int CHANNELS_OUT_DEF = 10;

	// frame constants
	localparam logic [7:0]  HDR_FIRST  = 8'h20;
	localparam logic [7:0]  HDR_SECOND = 8'h40;
	localparam logic [15:0] CKSUM_BASE = 16'hFFFF;

	// input request kind
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_IDLE = 1'b1;

	// result status codes
	localparam logic STATUS_CHAN  = 1'b0;
	localparam logic STATUS_CKERR = 1'b1;

	// frame-end event from collector to emitter
	typedef struct packed {
		logic done;
		logic err;
	} frame_end_t;

endpackage : ifp_pkg
`default_nettype wire

FILE: hdl/ibus_frame_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibus_frame_parser_core - i-BUS receive frame parser
// Input channel (in_valid/in_stall): one request per received UART byte
// (kind = data) or a line-idle marker (kind = idle) that drops a partial
// frame and restarts the header hunt. One request is taken every cycle unless in_stall is high.
// Output channel (out_valid/out_stall): after the last byte of a frame the
// first result is shown on the next cycle. A good frame gives one channel
// word per cycle while out_stall is low, index 0 upward, last set on the
// final one; a bad checksum gives a single error result with last set.
// Results sit in a snapshot buffer, so the next frame is collected while
// they drain. in_stall rises only while a frame waits on its final byte
// and the previous frame's results are still held by a stalled receiver.
// Reset clears the hunt state and drops any pending results; the channel
// word store is not cleared.
// ----------------------------------------------------------------------------
module ibus_frame_parser_core #(
	parameter int FRAME_BYTES  = ifp_pkg::FRAME_BYTES_DEF,
	parameter int CHANNELS_OUT = ifp_pkg::CHANNELS_OUT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic [3:0]       channel_index,
	output logic [15:0]      channel_value,
	output logic             last
);
	import ifp_pkg::*;

	frame_end_t                    fe;
	logic [CHANNELS_OUT-1:0][15:0] chan;
	logic                          emit_busy;

	// frame collection and checksum
	ifp_collect #(
		.FRAME_BYTES  (FRAME_BYTES),
		.CHANNELS_OUT (CHANNELS_OUT)
	) u_collect (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.rx_byte   (rx_byte),
		.emit_busy (emit_busy),
		.fe        (fe),
		.chan      (chan)
	);

	// result emission
	ifp_emit #(
		.FRAME_BYTES  (FRAME_BYTES),
		.CHANNELS_OUT (CHANNELS_OUT)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.fe            (fe),
		.chan          (chan),
		.emit_busy     (emit_busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.last          (last)
	);

endmodule : ibus_frame_parser_core
`default_nettype wire

FILE: hdl/ifp_collect.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifp_collect - header hunt, frame byte collection and checksum check
// Tracks the byte position, the running sum and the channel words of the
// frame in progress; flags frame end with the checksum verdict.
// ----------------------------------------------------------------------------
module ifp_collect #(
	parameter int FRAME_BYTES  = ifp_pkg::FRAME_BYTES_DEF,
	parameter int CHANNELS_OUT = ifp_pkg::CHANNELS_OUT_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             kind,
	input  wire logic [7:0]                       rx_byte,
	input  wire logic                             emit_busy,
	output ifp_pkg::frame_end_t                   fe,
	output logic [CHANNELS_OUT-1:0][15:0]         chan
);
	import ifp_pkg::*;

	localparam logic [POS_W-1:0] POS_HUNT   = '0;
	localparam logic [POS_W-1:0] POS_HDR2   = POS_W'(1);
	localparam logic [POS_W-1:0] POS_CK_LO  = POS_W'(FRAME_BYTES - 2);
	localparam logic [POS_W-1:0] POS_CK_HI  = POS_W'(FRAME_BYTES - 1);

	logic [POS_W-1:0]             pos_q;
	logic [15:0]                  sum_q;
	logic [7:0]                   low_q;
	logic [7:0]                   ck_low_q;
	logic [CHANNELS_OUT-1:0][15:0] store_q;

	logic                         accept;
	logic                         is_data;
	logic [POS_W-1:0]             off;
	logic [POS_W-2:0]             wr_ch;
	logic                         wr_en;
	logic [15:0]                  sum_add;
	logic [15:0]                  expect_ck;

	// hold off a frame end while the previous frame is still going out
	assign in_stall = emit_busy && (pos_q == POS_CK_HI);
	assign accept   = in_valid && !in_stall;
	assign is_data  = (kind == KIND_DATA);

	assign off       = pos_q - POS_W'(2);
	assign wr_ch     = off[POS_W-1:1];
	assign sum_add   = sum_q + {8'h00, rx_byte};
	assign expect_ck = CKSUM_BASE - sum_q;
	assign wr_en     = accept && is_data && (pos_q > POS_HDR2) && (pos_q < POS_CK_LO)
		&& off[0];

	// frame-end event
	assign fe.done = accept && is_data && (pos_q == POS_CK_HI);
	assign fe.err  = (expect_ck != {rx_byte, ck_low_q});
	assign chan    = store_q;

	// position, sum and byte holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_HUNT;
			sum_q    <= '0;
			low_q    <= '0;
			ck_low_q <= '0;
		end else if (accept) begin
			if (!is_data) begin
				pos_q <= POS_HUNT;
				sum_q <= '0;
			end else if (pos_q == POS_HUNT) begin
				if (rx_byte == HDR_FIRST) begin
					sum_q <= {8'h00, HDR_FIRST};
					pos_q <= POS_HDR2;
				end
			end else if (pos_q == POS_HDR2) begin
				if (rx_byte == HDR_SECOND) begin
					sum_q <= sum_add;
					pos_q <= pos_q + POS_W'(1);
				end else if (rx_byte == HDR_FIRST) begin
					sum_q <= {8'h00, HDR_FIRST};
					pos_q <= POS_HDR2;
				end else begin
					sum_q <= '0;
					pos_q <= POS_HUNT;
				end
			end else if (pos_q < POS_CK_LO) begin
				sum_q <= sum_add;
				if (!off[0]) begin
					low_q <= rx_byte;
				end
				pos_q <= pos_q + POS_W'(1);
			end else if (pos_q == POS_CK_LO) begin
				ck_low_q <= rx_byte;
				pos_q    <= pos_q + POS_W'(1);
			end else begin
				pos_q <= POS_HUNT;
				sum_q <= '0;
			end
		end
	end

	// channel word store, no reset
	always_ff @(posedge clk) begin
		for (int i = 0; i < CHANNELS_OUT; i++) begin
			if (wr_en && (wr_ch == (POS_W-1)'(i))) begin
				store_q[i] <= {rx_byte, low_q};
			end
		end
	end

endmodule : ifp_collect
`default_nettype wire

FILE: hdl/ifp_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifp_emit - result buffer and output channel
// Snapshots the channel words at frame end and sends them one per cycle
// while out_stall is low, or a single checksum-error result.
// ----------------------------------------------------------------------------
module ifp_emit #(
	parameter int FRAME_BYTES  = ifp_pkg::FRAME_BYTES_DEF,
	parameter int CHANNELS_OUT = ifp_pkg::CHANNELS_OUT_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire ifp_pkg::frame_end_t              fe,
	input  wire logic [CHANNELS_OUT-1:0][15:0]    chan,
	output logic                                  emit_busy,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  status,
	output logic [3:0]                            channel_index,
	output logic [15:0]                           channel_value,
	output logic                                  last
);
	import ifp_pkg::*;

	localparam int WORDS      = (FRAME_BYTES - 4) / 2;
	localparam int EMIT_COUNT = (CHANNELS_OUT < WORDS) ? CHANNELS_OUT : WORDS;
	localparam int IDX_W      = (EMIT_COUNT > 1) ? $clog2(EMIT_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(EMIT_COUNT - 1);

	logic                         active_q;
	logic                         err_q;
	logic [IDX_W-1:0]             idx_q;
	logic [EMIT_COUNT-1:0][15:0]  buf_q;
	logic [15:0]                  word;
	logic                         at_end;

	// pick the current word
	always_comb begin
		word = '0;
		for (int i = 0; i < EMIT_COUNT; i++) begin
			if (idx_q == IDX_W'(i)) begin
				word = buf_q[i];
			end
		end
	end

	assign at_end        = err_q || (idx_q == IDX_LAST);
	assign emit_busy     = active_q;
	assign out_valid     = active_q;
	assign status        = err_q ? STATUS_CKERR : STATUS_CHAN;
	assign channel_index = err_q ? 4'd0 : 4'(idx_q);
	assign channel_value = err_q ? 16'h0000 : word;
	assign last          = at_end;

	// emission control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			err_q    <= 1'b0;
			idx_q    <= '0;
		end else if (fe.done) begin
			active_q <= 1'b1;
			err_q    <= fe.err;
			idx_q    <= '0;
		end else if (active_q && !out_stall) begin
			if (at_end) begin
				active_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// snapshot of the frame's channel words
	always_ff @(posedge clk) begin
		if (fe.done) begin
			for (int i = 0; i < EMIT_COUNT; i++) begin
				buf_q[i] <= chan[i];
			end
		end
	end

endmodule : ifp_emit
`default_nettype wire

FILE: verif/ibus_frame_parser_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibus_frame_parser_core_test - self-checking bench for the i-BUS frame parser
// Feeds UART byte and line-idle requests and predicts the channel and
// checksum-error results with a local frame tracker. Each result is checked
// field by field, in order. Both channels take random stall and gap bursts.
// ----------------------------------------------------------------------------
module ibus_frame_parser_core_test;
	import ifp_pkg::*;

	localparam int FRAME_LEN     = FRAME_BYTES_DEF;
	localparam int CHANS         = CHANNELS_OUT_DEF;
	localparam int PAYLOAD_BYTES = FRAME_LEN - 4;
	localparam int PAYLOAD_WORDS = (PAYLOAD_BYTES + 1) / 2;
	localparam int EMIT_COUNT    = (CHANS < PAYLOAD_BYTES / 2) ? CHANS : PAYLOAD_BYTES / 2;
	localparam int REQUEST_TARGET = 280;
	localparam int CALM_TAIL     = 64;
	localparam int DRAIN_CYCLES  = 40;
	localparam int STUCK_LIMIT   = 500;

	typedef struct {
		logic       kind;
		logic [7:0] data;
	} rx_request_t;

	typedef struct {
		logic        status;
		logic [3:0]  idx;
		logic [15:0] value;
		logic        last;
	} chan_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = KIND_DATA;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        status;
	logic [3:0]  channel_index;
	logic [15:0] channel_value;
	logic        last;

	rx_request_t  rx_requests[$];
	chan_result_t expected_results[$];

	// frame tracker state
	int unsigned  frame_pos;
	logic [15:0]  frame_sum;
	logic [7:0]   word_lo_hold;
	logic [7:0]   cksum_lo_hold;
	logic [15:0]  chan_words[CHANS];

	logic [15:0]  frame_words[PAYLOAD_WORDS];
	int           request_total;
	int           requests_taken;
	int           results_seen;
	int           error_count;
	int           send_gap;
	int           hold_left;
	int           stuck_cycles;

	ibus_frame_parser_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.last          (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	// advance the frame tracker by one accepted request, queue what it emits
	task automatic parse_rx_request(input logic k, input logic [7:0] b);
		int unsigned  off;
		logic [15:0]  want_ck;
		logic [15:0]  got_ck;
		chan_result_t r;
		if (k == KIND_IDLE) begin
			frame_pos = 0;
			frame_sum = 16'h0000;
		end else if (frame_pos == 0) begin
			if (b == HDR_FIRST) begin
				frame_sum = 16'(HDR_FIRST);
				frame_pos = 1;
			end
		end else if (frame_pos == 1) begin
			if (b == HDR_SECOND) begin
				frame_sum = frame_sum + b;
				frame_pos = 2;
			end else if (b == HDR_FIRST) begin
				frame_sum = 16'(HDR_FIRST);
				frame_pos = 1;
			end else begin
				frame_sum = 16'h0000;
				frame_pos = 0;
			end
		end else if (frame_pos < FRAME_LEN - 2) begin
			off = frame_pos - 2;
			frame_sum = frame_sum + b;
			if (off % 2 == 0)
				word_lo_hold = b;
			else if (off / 2 < CHANS)
				chan_words[off / 2] = {b, word_lo_hold};
			frame_pos = frame_pos + 1;
		end else if (frame_pos == FRAME_LEN - 2) begin
			cksum_lo_hold = b;
			frame_pos = frame_pos + 1;
		end else begin
			// final byte: checksum compare, then emit
			want_ck = CKSUM_BASE - frame_sum;
			got_ck = {b, cksum_lo_hold};
			frame_pos = 0;
			frame_sum = 16'h0000;
			if (want_ck != got_ck) begin
				r.status = STATUS_CKERR;
				r.idx = 4'd0;
				r.value = 16'h0000;
				r.last = 1'b1;
				expected_results.push_back(r);
			end else begin
				for (int i = 0; i < EMIT_COUNT; i++) begin
					r.status = STATUS_CHAN;
					r.idx = 4'(i);
					r.value = chan_words[i];
					r.last = (i == EMIT_COUNT - 1);
					expected_results.push_back(r);
				end
			end
		end
	endtask

	task automatic queue_byte(input logic [7:0] b);
		rx_request_t q;
		q.kind = KIND_DATA;
		q.data = b;
		rx_requests.push_back(q);
	endtask

	task automatic queue_idle();
		rx_request_t q;
		q.kind = KIND_IDLE;
		q.data = 8'($urandom_range(0, 255));
		rx_requests.push_back(q);
	endtask

	// full frame from frame_words; corrupt flips checksum bits
	task automatic queue_frame(input bit corrupt);
		logic [15:0] acc;
		logic [15:0] cks;
		logic [7:0]  b;
		acc = 16'(HDR_FIRST) + 16'(HDR_SECOND);
		queue_byte(HDR_FIRST);
		queue_byte(HDR_SECOND);
		for (int p = 0; p < PAYLOAD_BYTES; p++) begin
			b = (p % 2 == 0) ? frame_words[p / 2][7:0] : frame_words[p / 2][15:8];
			acc = acc + b;
			queue_byte(b);
		end
		cks = CKSUM_BASE - acc;
		if (corrupt)
			cks = cks ^ 16'($urandom_range(1, 65535));
		queue_byte(cks[7:0]);
		queue_byte(cks[15:8]);
	endtask

	// frame cut short after n bytes, dropped by a line-idle request
	task automatic queue_partial(input int n);
		for (int i = 0; i < n; i++) begin
			if (i == 0)
				queue_byte(HDR_FIRST);
			else if (i == 1)
				queue_byte(HDR_SECOND);
			else
				queue_byte(8'($urandom_range(0, 255)));
		end
		queue_idle();
	endtask

	function automatic logic [15:0] pick_word();
		int sel;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			return 16'h0000;
		if (sel == 1)
			return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic fill_random_words();
		for (int w = 0; w < PAYLOAD_WORDS; w++)
			frame_words[w] = pick_word();
	endtask

	// request driver: holds each request until taken, random gap bursts
	always @(posedge clk or negedge arst_n) begin : drive_requests
		rx_request_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_DATA;
			rx_byte <= 8'h00;
			send_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (rx_requests.size() != 0) begin
				req = rx_requests.pop_front();
				in_valid <= 1'b1;
				kind <= req.kind;
				rx_byte <= req.data;
				if (rx_requests.size() >= CALM_TAIL && $urandom_range(0, 11) == 0)
					send_gap <= $urandom_range(1, 18);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: predicts on taken requests, checks taken results, drives out_stall
	always @(posedge clk or negedge arst_n) begin : watch_channels
		chan_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				parse_rx_request(kind, rx_byte);
				requests_taken++;
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_error($sformatf("unexpected result idx %0d value %h",
						channel_index, channel_value));
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status)
						report_error($sformatf("result %0d status got %b want %b",
							results_seen, status, want.status));
					if (channel_index !== want.idx)
						report_error($sformatf("result %0d channel_index got %0d want %0d",
							results_seen, channel_index, want.idx));
					if (channel_value !== want.value)
						report_error($sformatf("result %0d channel_value got %h want %h",
							results_seen, channel_value, want.value));
					if (last !== want.last)
						report_error($sformatf("result %0d last got %b want %b",
							results_seen, last, want.last));
				end
				results_seen++;
			end
			// random receiver stall bursts, none near the end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (rx_requests.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				hold_left <= $urandom_range(0, 17);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: too long with work outstanding and no handshake on either side
	always @(posedge clk) begin
		if (arst_n && (requests_taken != request_total || expected_results.size() != 0)
				&& !(in_valid && !in_stall) && !(out_valid && !out_stall))
			stuck_cycles++;
		else
			stuck_cycles = 0;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int pick;
		int n;
		frame_pos = 0;
		frame_sum = 16'h0000;
		word_lo_hold = 8'h00;
		cksum_lo_hold = 8'h00;
		for (int i = 0; i < CHANS; i++)
			chan_words[i] = 16'h0000;
		requests_taken = 0;
		results_seen = 0;
		error_count = 0;
		stuck_cycles = 0;

		// directed: idle while hunting, stray bytes, header restarts
		queue_idle();
		queue_byte(HDR_SECOND);
		queue_byte(8'hFF);
		queue_byte(8'h00);
		queue_byte(HDR_FIRST);
		queue_byte(8'h13);
		queue_byte(HDR_FIRST);
		queue_idle();
		// repeated first header byte, then a good frame with extreme and
		// header-like words
		queue_byte(HDR_FIRST);
		for (int w = 0; w < PAYLOAD_WORDS; w++)
			frame_words[w] = {HDR_FIRST, HDR_FIRST};
		frame_words[0] = 16'h0000;
		frame_words[1] = 16'hFFFF;
		frame_words[2] = {HDR_SECOND, HDR_FIRST};
		frame_words[3] = {HDR_FIRST, HDR_SECOND};
		queue_frame(1'b0);
		// bad checksum
		fill_random_words();
		queue_frame(1'b1);
		// frame dropped by line idle just before its last byte, then good ones
		queue_partial(FRAME_LEN - 1);
		for (int w = 0; w < PAYLOAD_WORDS; w++)
			frame_words[w] = 16'hFFFF;
		queue_frame(1'b0);
		fill_random_words();
		queue_frame(1'b0);

		// random: mostly well-formed frames, some broken and noise
		while (rx_requests.size() < REQUEST_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				fill_random_words();
				queue_frame($urandom_range(0, 6) == 0);
			end else if (pick < 77) begin
				queue_partial($urandom_range(1, FRAME_LEN - 1));
			end else if (pick < 87) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					queue_byte(($urandom_range(0, 2) == 0) ? HDR_FIRST
						: 8'($urandom_range(0, 255)));
				queue_idle();
			end else if (pick < 93) begin
				queue_idle();
			end else begin
				queue_byte(HDR_FIRST);
				fill_random_words();
				queue_frame(1'b0);
			end
		end
		request_total = rx_requests.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (requests_taken != request_total || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: files.f
hdl/ifp_pkg.sv
hdl/ifp_collect.sv
hdl/ifp_emit.sv
hdl/ibus_frame_parser_core.sv
verif/ibus_frame_parser_core_test.sv
